FILE: src/ahcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ahcp_pkg;
    localparam int OffsetBitsDefault = 32;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_FVER = 32'h46564552;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [31:0] TAG_APCM = 32'h4150434D;
    localparam logic [31:0] VERSION_WORD = 32'hA2805140;
    localparam logic [31:0] CODE_NONE = 32'h454E4F4E;
    localparam logic [31:0] CODE_RAW = 32'h20776172;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_AIFF = 3'd1;
    localparam logic [2:0] ST_BAD_VLEN = 3'd2;
    localparam logic [2:0] ST_BAD_VER = 3'd3;
    localparam logic [2:0] ST_SHORT_COMM = 3'd4;
    localparam logic [2:0] ST_TRUNC = 3'd5;
    localparam logic [2:0] ST_NO_COMM = 3'd6;
    localparam logic [2:0] ST_NO_SOUND = 3'd7;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PREAMBLE, PH_VERSION, PH_COMMON, PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        stream_end;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] frame_count;
        logic [15:0] bits_per_sample;
        logic [31:0] sample_rate;
        logic [31:0] format_code;
        logic        compressed_form;
        logic [31:0] data_start;
        logic [32:0] data_end;
        logic [31:0] bytes_per_second;
        logic [31:0] duration_seconds;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic start;     // latch finished parse, begin end-of-file arithmetic
        logic deliver;   // result taken, clear
    } t_cmd;

    typedef struct packed {
        logic done;      // arithmetic finished, result ready
    } t_sts;
endpackage
`default_nettype wire

FILE: src/ahcp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ahcp_in_if import ahcp_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ahcp_out_if import ahcp_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/aiff_header_chunk_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   data_byte[8], stream_end[1]
// out_ch    out  one result per stream_end
// Data bytes are taken one per cycle while in the run state; none are taken while the
// arithmetic runs or the result waits. An end marker starts the end-of-file arithmetic:
// a multiply by bytes per sample, a multiply by channels, a check, the serial divider and a load.
// The result waits in its register until taken; then the parser rearms.
// Reset (synchronous, active low) returns the parser to the header phase.
module aiff_header_chunk_parser import ahcp_pkg::*; #(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ahcp_in_if.sink   in_ch,
    ahcp_out_if.source out_ch
);
    logic w_byte_en, w_clear, w_aifc, w_sound;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [2:0] w_status;
    logic [15:0] w_ch, w_bits;
    logic [31:0] w_frames, w_mant, w_fmt, w_dstart, w_len;
    logic [32:0] w_dend;
    logic [7:0] w_exp;

    ahcp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .i_in_end(in_ch.data.stream_end), .i_out_ready(out_ch.ready), .i_sts(w_sts),
        .o_in_ready(in_ch.ready), .o_out_valid(out_ch.valid), .o_byte_en(w_byte_en),
        .o_clear(w_clear), .o_cmd(w_cmd)
    );

    ahcp_parse #(.OFFSET_BITS(OFFSET_BITS)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_byte_en(w_byte_en),
        .i_byte(in_ch.data.data_byte), .i_clear(w_clear), .o_status(w_status),
        .o_aifc(w_aifc), .o_ch(w_ch), .o_bits(w_bits), .o_frames(w_frames),
        .o_mant(w_mant), .o_exp(w_exp), .o_fmt(w_fmt), .o_dstart(w_dstart),
        .o_dend(w_dend), .o_len(w_len), .o_sound(w_sound)
    );

    ahcp_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_status(w_status),
        .i_aifc(w_aifc), .i_ch(w_ch), .i_bits(w_bits), .i_frames(w_frames),
        .i_mant(w_mant), .i_exp(w_exp), .i_fmt(w_fmt), .i_dstart(w_dstart),
        .i_dend(w_dend), .i_len(w_len), .i_sound(w_sound),
        .o_sts(w_sts), .o_res(out_ch.data)
    );
endmodule
`default_nettype wire

FILE: src/ahcp_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte-wise chunk walker; captures header fields.
module ahcp_parse import ahcp_pkg::*; #(
    parameter int OFFSET_BITS = OffsetBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_byte_en,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_clear,
    output logic [2:0]       o_status,
    output logic             o_aifc,
    output logic [15:0]      o_ch,
    output logic [15:0]      o_bits,
    output logic [31:0]      o_frames,
    output logic [31:0]      o_mant,
    output logic [7:0]       o_exp,
    output logic [31:0]      o_fmt,
    output logic [31:0]      o_dstart,
    output logic [32:0]      o_dend,
    output logic [31:0]      o_len,
    output logic             o_sound
);
    t_phase r_ph;
    logic [OFFSET_BITS-1:0] r_off;
    logic [31:0] r_tag, r_clen;
    logic [32:0] r_left;
    logic [3:0]  r_cnt;
    logic        r_aifc, r_halt, r_sound;
    logic [2:0]  r_err;
    logic [15:0] r_ch, r_bits;
    logic [31:0] r_frames, r_mant, r_fmt, r_len, r_dstart;
    logic [32:0] r_dend;
    logic [7:0]  r_exp;
    logic [32:0] w_idx;
    logic [31:0] w_ntag, w_nlen;
    logic [OFFSET_BITS:0] w_ds;

    assign w_idx  = {1'b0, r_clen} - r_left;
    assign w_ntag = {r_tag[23:0], i_byte};
    assign w_nlen = {r_clen[23:0], i_byte};
    // body offset counts the current byte, sound data starts eight past it
    assign w_ds   = {1'b0, r_off} + (OFFSET_BITS+1)'(9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ph <= PH_HEADER; r_off <= '0; r_tag <= '0; r_clen <= '0;
            r_left <= '0; r_cnt <= '0; r_aifc <= 1'b0; r_halt <= 1'b0;
            r_sound <= 1'b0; r_err <= ST_OK;
            r_ch <= '0; r_bits <= 16'd16; r_frames <= '0; r_mant <= '0;
            r_exp <= '0; r_fmt <= CODE_RAW; r_len <= '0; r_dstart <= '0;
            r_dend <= '0;
        end else if (i_byte_en) begin
            r_off <= r_off + 1'b1;
            if (!r_halt) begin
                unique case (r_ph)
                    PH_HEADER: begin
                        r_tag <= w_ntag;
                        if (r_cnt == 4'd11) r_cnt <= '0;
                        else r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 4'd3 && w_ntag != TAG_FORM) begin
                            r_halt <= 1'b1; r_err <= ST_NOT_AIFF;
                        end else if (r_cnt == 4'd11) begin
                            if (w_ntag == TAG_AIFC) begin
                                r_aifc <= 1'b1; r_ph <= PH_PREAMBLE;
                            end else if (w_ntag == TAG_AIFF) begin
                                r_ph <= PH_PREAMBLE;
                            end else begin
                                r_halt <= 1'b1; r_err <= ST_NOT_AIFF;
                            end
                        end
                    end
                    PH_PREAMBLE: begin
                        if (r_cnt < 4'd4) r_tag <= w_ntag;
                        else r_clen <= w_nlen;
                        if (r_cnt == 4'd7) begin
                            r_cnt <= '0;
                            if (r_tag == TAG_FVER) begin
                                if (w_nlen != 32'd4) begin
                                    r_halt <= 1'b1; r_err <= ST_BAD_VLEN;
                                end else begin
                                    r_tag <= '0; r_left <= 33'd4; r_ph <= PH_VERSION;
                                end
                            end else if (r_tag == TAG_COMM) begin
                                if (w_nlen < (r_aifc ? 32'd22 : 32'd18)) begin
                                    r_halt <= 1'b1; r_err <= ST_SHORT_COMM;
                                end else begin
                                    r_left <= {1'b0, w_nlen}; r_ph <= PH_COMMON;
                                    r_ch <= '0; r_frames <= '0; r_bits <= '0;
                                    r_exp <= 8'd30; r_mant <= '0;
                                    if (r_aifc) r_fmt <= '0;
                                end
                            end else begin
                                if (r_tag == TAG_SSND || r_tag == TAG_APCM) begin
                                    r_dstart <= 32'(w_ds[OFFSET_BITS-1:0]);
                                    r_dend <= 33'(w_ds[OFFSET_BITS-1:0]) + {1'b0, w_nlen};
                                    r_len <= w_nlen; r_sound <= 1'b1;
                                end
                                r_left <= {1'b0, w_nlen} + {32'd0, r_aifc & w_nlen[0]};
                                if (w_nlen == 0 && !(r_aifc & w_nlen[0])) r_ph <= PH_PREAMBLE;
                                else r_ph <= PH_SKIP;
                            end
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    PH_VERSION: begin
                        r_tag <= w_ntag;
                        r_left <= r_left - 1'b1;
                        if (r_left == 33'd1) begin
                            if (w_ntag == VERSION_WORD) begin
                                r_aifc <= 1'b1; r_ph <= PH_PREAMBLE;
                            end else begin
                                r_halt <= 1'b1; r_err <= ST_BAD_VER;
                            end
                        end
                    end
                    PH_COMMON: begin
                        // fields bytewise, big-endian, fmt LE; drop rest
                        if (w_idx < 33'd22) begin
                            case (w_idx[4:0])
                                5'd0: r_ch[15:8] <= i_byte;
                                5'd1: r_ch[7:0] <= i_byte;
                                5'd2: r_frames[31:24] <= i_byte;
                                5'd3: r_frames[23:16] <= i_byte;
                                5'd4: r_frames[15:8] <= i_byte;
                                5'd5: r_frames[7:0] <= i_byte;
                                5'd6: r_bits[15:8] <= i_byte;
                                5'd7: r_bits[7:0] <= i_byte;
                                5'd9: r_exp <= 8'd30 - i_byte;
                                5'd10: r_mant[31:24] <= i_byte;
                                5'd11: r_mant[23:16] <= i_byte;
                                5'd12: r_mant[15:8] <= i_byte;
                                5'd13: r_mant[7:0] <= i_byte;
                                5'd18: if (r_aifc) r_fmt[7:0] <= i_byte;
                                5'd19: if (r_aifc) r_fmt[15:8] <= i_byte;
                                5'd20: if (r_aifc) r_fmt[23:16] <= i_byte;
                                5'd21: if (r_aifc) r_fmt[31:24] <= i_byte;
                                default: ;
                            endcase
                        end
                        if (r_left == 33'd1) begin
                            if (r_aifc & r_clen[0]) begin
                                r_left <= 33'd1; r_ph <= PH_SKIP;
                            end else begin
                                r_left <= '0; r_ph <= PH_PREAMBLE;
                            end
                        end else begin
                            r_left <= r_left - 1'b1;
                        end
                    end
                    default: begin
                        if (r_left <= 33'd1) begin
                            r_left <= '0; r_ph <= PH_PREAMBLE;
                        end else begin
                            r_left <= r_left - 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (r_halt) o_status = r_err;
        else if (r_ph == PH_HEADER) o_status = ST_NOT_AIFF;
        else if (r_ph == PH_VERSION || r_ph == PH_COMMON) o_status = ST_TRUNC;
        else o_status = ST_OK;
    end
    assign o_aifc = r_aifc;
    assign o_ch = r_ch;
    assign o_bits = r_bits;
    assign o_frames = r_frames;
    assign o_mant = r_mant;
    assign o_exp = r_exp;
    assign o_fmt = (r_fmt == CODE_NONE) ? CODE_RAW : r_fmt;
    assign o_dstart = r_dstart;
    assign o_dend = r_dend;
    assign o_len = r_len;
    assign o_sound = r_sound;
endmodule
`default_nettype wire

FILE: src/ahcp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// End-of-file arithmetic: rate, bytes per second, serial division.
module ahcp_datapath import ahcp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [2:0]  i_status,
    input  wire logic        i_aifc,
    input  wire logic [15:0] i_ch,
    input  wire logic [15:0] i_bits,
    input  wire logic [31:0] i_frames,
    input  wire logic [31:0] i_mant,
    input  wire logic [7:0]  i_exp,
    input  wire logic [31:0] i_fmt,
    input  wire logic [31:0] i_dstart,
    input  wire logic [32:0] i_dend,
    input  wire logic [31:0] i_len,
    input  wire logic        i_sound,
    output t_sts             o_sts,
    output t_out             o_res
);
    logic [2:0]  r_step;
    logic [5:0]  r_bit;
    logic [31:0] r_rate, r_bps, r_quo, r_rem_len;
    logic [32:0] r_rem;
    logic [47:0] r_prod;
    logic        r_busy, r_done;
    logic [2:0]  r_status;
    logic        r_cf;
    t_out        r_res;
    t_out        w_res;
    logic [31:0] w_sh, w_rnd;
    logic [32:0] w_try;

    assign w_sh  = (i_exp >= 8'd32) ? 32'd0 : (i_mant >> i_exp[4:0]);
    assign w_rnd = (i_exp == 8'd0 || i_exp > 8'd32) ? 32'd0
                 : 32'((i_mant >> (i_exp[5:0] - 6'd1)) & 32'd1);
    assign w_try = {r_rem[31:0], r_rem_len[31]};

    // zero every field but status and form unless the parse is good
    always_comb begin
        w_res = '0;
        w_res.status = r_status;
        w_res.compressed_form = r_cf;
        if (r_status == ST_OK) begin
            w_res.channels = i_ch;
            w_res.frame_count = i_frames;
            w_res.bits_per_sample = i_bits;
            w_res.sample_rate = r_rate;
            w_res.format_code = i_fmt;
            w_res.data_start = i_dstart;
            w_res.data_end = i_dend;
            w_res.bytes_per_second = r_bps;
            w_res.duration_seconds = r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.deliver) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_step <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1; r_step <= 3'd0;
            r_status <= i_status;
            r_cf <= i_aifc;
            r_rate <= (i_exp == 8'd0) ? i_mant : w_sh + w_rnd;
        end else if (r_busy) begin
            case (r_step)
                3'd0: begin
                    r_prod <= 48'(r_rate) * 48'({3'd0, i_bits[15:3]});
                    r_step <= 3'd1;
                end
                3'd1: begin
                    r_bps <= 32'(r_prod[31:0] * i_ch);
                    r_step <= 3'd2;
                end
                3'd2: begin
                    if (r_status == ST_OK && r_bps == 0)
                        r_status <= ST_NO_COMM;
                    else if (r_status == ST_OK && !i_sound)
                        r_status <= ST_NO_SOUND;
                    r_rem <= '0; r_rem_len <= i_len; r_quo <= '0; r_bit <= '0;
                    r_step <= 3'd3;
                end
                3'd3: begin
                    if (w_try >= {1'b0, r_bps}) begin
                        r_rem <= w_try - {1'b0, r_bps};
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= w_try;
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_rem_len <= {r_rem_len[30:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 6'd31) r_step <= 3'd4;
                end
                default: begin
                    r_res <= w_res;
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            endcase
        end
    end

    assign o_sts.done = r_done;
    assign o_res = r_res;
endmodule
`default_nettype wire

FILE: src/ahcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Request sequencer: bytes pass straight to the parser; end marker runs arithmetic.
module ahcp_ctrl import ahcp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_end,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output logic      o_byte_en,
    output logic      o_clear,
    output t_cmd      o_cmd
);
    typedef enum logic [1:0] {S_RUN, S_CALC, S_SHOW} t_state;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            unique case (r_state)
                S_RUN:  if (i_in_valid && i_in_end) r_state <= S_CALC;
                S_CALC: if (i_sts.done) r_state <= S_SHOW;
                default: if (i_out_ready) r_state <= S_RUN;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_RUN);
    assign o_byte_en   = o_in_ready && i_in_valid && !i_in_end;
    assign o_cmd.start = o_in_ready && i_in_valid && i_in_end;
    assign o_out_valid = (r_state == S_SHOW);
    assign o_cmd.deliver = o_out_valid && i_out_ready;
    assign o_clear     = o_cmd.deliver;
endmodule
`default_nettype wire
